FILE: rtl/core/contour_cell_segments_core_defines.svh
// ----------------------------------------------------------------------------
// Contour cell segments: assertion macros
// Shared concurrent assertion forms for the contour cell segment core.
// ----------------------------------------------------------------------------
`ifndef CONTOUR_CELL_SEGMENTS_CORE_DEFINES_SVH
`define CONTOUR_CELL_SEGMENTS_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define CCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define CCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/ccs_pkg.sv
// ----------------------------------------------------------------------------
// Contour cell segments package
// Widths, sequencer states, triangle case table and endpoint decode.
// ----------------------------------------------------------------------------
package ccs_pkg;

   localparam int DEF_MAX_LEVELS = 16;

   localparam int COORD_W = 16;  // input coordinates and heights
   localparam int P_W     = 20;  // Q16.4 coordinates
   localparam int H_W     = 20;  // heights relative to a level, times four
   localparam int MAG_W   = 18;  // magnitude of such a height
   localparam int DEN_W   = MAG_W + 1;
   localparam int PROD_W  = MAG_W + P_W;
   localparam int NUM_W   = PROD_W + 1;
   localparam int LEV_W   = 22;  // level height, up to base plus 15 steps
   localparam int LIDX_W  = 4;
   localparam int CIDX_W  = 2;
   localparam int CNT_W   = 5;   // level_count register width
   localparam int DCNT_W  = 5;   // divider step counter

   localparam logic [CIDX_W-1:0] CSR_LEVEL_BASE  = 2'd0;
   localparam logic [CIDX_W-1:0] CSR_LEVEL_STEP  = 2'd1;
   localparam logic [CIDX_W-1:0] CSR_LEVEL_COUNT = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LEVEL,
      ST_CENTER,
      ST_TRI,
      ST_ENDP,
      ST_MULA,
      ST_MULB,
      ST_DIVLD,
      ST_DIV,
      ST_PUSH,
      ST_FLUSH
   } state_type;

   // Triangle vertex roles: a and b are cell corners, c is the centre.
   typedef enum logic [1:0] {
      ROLE_A,
      ROLE_C,
      ROLE_B
   } role_type;

   typedef struct packed {
      logic     is_x;   // endpoint is an edge crossing between r1 and r2
      role_type r1;
      role_type r2;
   } endp_type;

   // Sign codes: 0 below the level, 1 on it, 2 above it.
   localparam logic [3:0] CASE_TAB [27] = '{
      4'd0, 4'd0, 4'd8,  4'd0, 4'd2, 4'd5,  4'd7, 4'd6, 4'd9,
      4'd0, 4'd3, 4'd4,  4'd1, 4'd3, 4'd1,  4'd4, 4'd3, 4'd0,
      4'd9, 4'd6, 4'd7,  4'd5, 4'd2, 4'd0,  4'd8, 4'd0, 4'd0
   };

   function automatic logic [1:0] sign_code(input logic signed [H_W-1:0] h);
      logic [1:0] s;
      if (h == '0) s = 2'd1;
      else if (h[H_W-1]) s = 2'd0;
      else s = 2'd2;
      return s;
   endfunction

   function automatic logic [3:0] case_lookup(input logic [1:0] sa, input logic [1:0] sc,
                                              input logic [1:0] sb);
      logic [4:0] idx;
      idx = 5'(sa) * 5'd9 + 5'(sc) * 5'd3 + 5'(sb);
      return CASE_TAB[idx];
   endfunction

   function automatic endp_type endp_decode(input logic [3:0] cv, input logic e);
      endp_type r;
      r = '{is_x: 1'b0, r1: ROLE_A, r2: ROLE_A};
      unique case (cv)
         4'd1: r = e ? '{1'b0, ROLE_C, ROLE_C} : '{1'b0, ROLE_A, ROLE_A};
         4'd2: r = e ? '{1'b0, ROLE_B, ROLE_B} : '{1'b0, ROLE_C, ROLE_C};
         4'd3: r = e ? '{1'b0, ROLE_A, ROLE_A} : '{1'b0, ROLE_B, ROLE_B};
         4'd4: r = e ? '{1'b1, ROLE_C, ROLE_B} : '{1'b0, ROLE_A, ROLE_A};
         4'd5: r = e ? '{1'b1, ROLE_B, ROLE_A} : '{1'b0, ROLE_C, ROLE_C};
         4'd6: r = e ? '{1'b1, ROLE_A, ROLE_C} : '{1'b0, ROLE_B, ROLE_B};
         4'd7: r = e ? '{1'b1, ROLE_C, ROLE_B} : '{1'b1, ROLE_A, ROLE_C};
         4'd8: r = e ? '{1'b1, ROLE_B, ROLE_A} : '{1'b1, ROLE_C, ROLE_B};
         4'd9: r = e ? '{1'b1, ROLE_A, ROLE_C} : '{1'b1, ROLE_B, ROLE_A};
         default: r = '{is_x: 1'b0, r1: ROLE_A, r2: ROLE_A};
      endcase
      return r;
   endfunction

   // Vertex number (0 centre, 1..4 corners) of a role in triangle t.
   function automatic logic [2:0] role_vertex(input role_type role, input logic [1:0] t);
      logic [2:0] v;
      unique case (role)
         ROLE_A:  v = 3'(t) + 3'd1;
         ROLE_B:  v = (t == 2'd3) ? 3'd1 : 3'(t) + 3'd2;
         ROLE_C:  v = 3'd0;
         default: v = 3'd0;
      endcase
      return v;
   endfunction

   function automatic logic [MAG_W-1:0] mag_of(input logic signed [H_W-1:0] h);
      logic [H_W-1:0] a;
      a = h[H_W-1] ? H_W'(-h) : H_W'(h);
      return a[MAG_W-1:0];
   endfunction

endpackage

FILE: rtl/core/contour_cell_segments_core.sv
// ----------------------------------------------------------------------------
// Contour cell segments core
// Contour line segments of one grid cell over up to MAX_LEVELS levels, four
// triangles around the centre, crossings found by one shared multiplier and
// one shared restoring divider.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid/req_stall  | four corner heights, cell edges
//  rsp_    | out       | rsp_valid/rsp_stall  | level index, segment ends, last
//  csr_    | in        | csr_valid/csr_ready  | register index, write data
//
// A cell passes through the accepting idle state, a scan over the levels, with a
// centre and triangle pass for each level inside the corner range, and the flush;
// per segment come the endpoint states, for each crossing endpoint the multiplier
// and the 20-step divider loop once per axis, and the hand-over. Output stalls
// hold the hand-over and the flush. A new cell is taken only in the idle state.
// Reset is synchronous and clears the control state, output flags and level registers.
module contour_cell_segments_core #(
   parameter int MAX_LEVELS = ccs_pkg::DEF_MAX_LEVELS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [ccs_pkg::COORD_W-1:0] req_height_sw,
   input  logic signed [ccs_pkg::COORD_W-1:0] req_height_se,
   input  logic signed [ccs_pkg::COORD_W-1:0] req_height_ne,
   input  logic signed [ccs_pkg::COORD_W-1:0] req_height_nw,
   input  logic [ccs_pkg::COORD_W-1:0]       req_x_lo,
   input  logic [ccs_pkg::COORD_W-1:0]       req_x_hi,
   input  logic [ccs_pkg::COORD_W-1:0]       req_y_lo,
   input  logic [ccs_pkg::COORD_W-1:0]       req_y_hi,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ccs_pkg::LIDX_W-1:0]        rsp_level_index,
   output logic [ccs_pkg::P_W-1:0]           rsp_start_x,
   output logic [ccs_pkg::P_W-1:0]           rsp_start_y,
   output logic [ccs_pkg::P_W-1:0]           rsp_end_x,
   output logic [ccs_pkg::P_W-1:0]           rsp_end_y,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ccs_pkg::CIDX_W-1:0]        csr_index,
   input  logic [ccs_pkg::COORD_W-1:0]       csr_wdata
);
   import ccs_pkg::*;
   `include "contour_cell_segments_core_defines.svh"

   localparam int KW = $clog2(MAX_LEVELS + 1);

   state_type state_ff, state_in;

   logic signed [COORD_W-1:0] base_ff;
   logic [COORD_W-1:0]        step_ff;
   logic [CNT_W-1:0]          lcount_ff;

   logic signed [COORD_W-1:0] cor_ff [4];
   logic signed [COORD_W-1:0] lo_ff, hi_ff;
   logic [COORD_W-1:0]        xl_ff, xr_ff, yl_ff, yr_ff;
   logic signed [LEV_W-1:0]   lev_ff;
   logic [KW-1:0]             k_ff, kcount_ff;
   logic signed [H_W-1:0]     h_ff [5];
   logic [1:0]                t_ff;
   logic [3:0]                cv_ff;
   logic                      e_ff, axis_ff;
   logic [MAG_W-1:0]          magu_ff, magv_ff;
   logic [P_W-1:0]            pux_ff, puy_ff, pvx_ff, pvy_ff;
   logic [PROD_W-1:0]         prod_ff, prod2_ff;
   logic [DEN_W-1:0]          den_ff;
   logic [DEN_W-1:0]          rem_ff;
   logic [P_W-1:0]            sh_ff;
   logic [DCNT_W-1:0]         dcnt_ff;
   logic [P_W-1:0]            sx_ff, sy_ff, ex_ff, ey_ff;

   logic                      pend_valid_ff;
   logic [LIDX_W-1:0]         pend_lidx_ff;
   logic [P_W-1:0]            pend_sx_ff, pend_sy_ff, pend_ex_ff, pend_ey_ff;
   logic                      out_valid_ff, out_last_ff;
   logic [LIDX_W-1:0]         out_lidx_ff;
   logic [P_W-1:0]            out_sx_ff, out_sy_ff, out_ex_ff, out_ey_ff;

   // Control decoded from the state.
   logic                      req_take, out_free, out_load, lev_out, tri_empty, div_last;
   logic signed [COORD_W-1:0] lo_in, hi_in, lo_a, lo_b, hi_a, hi_b;
   logic [KW-1:0]             kcount_in;
   logic [3:0]                cv_in;
   endp_type                  ep;
   logic [2:0]                vu, vv;
   logic [P_W-1:0]            xmid, ymid, vux, vuy, vvx, vvy;
   logic [MAG_W-1:0]          mul_h;
   logic [P_W-1:0]            mul_p;
   logic [PROD_W-1:0]         mul_out;
   logic [NUM_W-1:0]          num;
   logic [DEN_W:0]            dtry;
   logic                      dge;
   logic [DEN_W:0]            dsub;
   logic [P_W-1:0]            quot;
   logic signed [LEV_W-1:0]   dlev [4];
   logic signed [H_W-1:0]     hsum;

   function automatic logic [P_W-1:0] vcoord(input logic [2:0] v, input logic ax,
                                            input logic [P_W-1:0] xm,
                                            input logic [P_W-1:0] ym,
                                            input logic [COORD_W-1:0] xl,
                                            input logic [COORD_W-1:0] xr,
                                            input logic [COORD_W-1:0] yl,
                                            input logic [COORD_W-1:0] yr);
      logic [P_W-1:0] r;
      if (!ax) begin
         unique case (v)
            3'd0:       r = xm;
            3'd1, 3'd4: r = {xl, 4'b0000};
            default:    r = {xr, 4'b0000};
         endcase
      end else begin
         unique case (v)
            3'd0:       r = ym;
            3'd1, 3'd2: r = {yl, 4'b0000};
            default:    r = {yr, 4'b0000};
         endcase
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- control
   always_comb begin
      req_stall = reset || (state_ff != ST_IDLE);
      csr_ready = !reset;
      req_take  = req_valid && !req_stall;
      out_free  = !out_valid_ff || !rsp_stall;
      out_load  = out_free && pend_valid_ff &&
                  ((state_ff == ST_PUSH) || (state_ff == ST_FLUSH));
      lev_out   = (lev_ff < LEV_W'(lo_ff)) || (lev_ff > LEV_W'(hi_ff));
      cv_in     = case_lookup(sign_code(h_ff[role_vertex(ROLE_A, t_ff)]), sign_code(h_ff[0]),
                              sign_code(h_ff[role_vertex(ROLE_B, t_ff)]));
      tri_empty = (cv_in == 4'd0);
      div_last  = (dcnt_ff == DCNT_W'(P_W - 1));
      ep        = endp_decode(cv_ff, e_ff);
      vu        = role_vertex(ep.r1, t_ff);
      vv        = role_vertex(ep.r2, t_ff);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_take) state_in = ST_LEVEL;
         ST_LEVEL: begin
            if (k_ff == kcount_ff) state_in = ST_FLUSH;
            else if (!lev_out) state_in = ST_CENTER;
         end
         ST_CENTER: state_in = ST_TRI;
         ST_TRI: begin
            if (!tri_empty) state_in = ST_ENDP;
            else if (t_ff == 2'd3) state_in = ST_LEVEL;
         end
         ST_ENDP: begin
            if (ep.is_x) state_in = ST_MULA;
            else if (e_ff) state_in = ST_PUSH;
         end
         ST_MULA:   state_in = ST_MULB;
         ST_MULB:   state_in = ST_DIVLD;
         ST_DIVLD:  state_in = ST_DIV;
         ST_DIV: begin
            if (div_last) begin
               if (!axis_ff) state_in = ST_MULA;
               else if (e_ff) state_in = ST_PUSH;
               else state_in = ST_ENDP;
            end
         end
         ST_PUSH: begin
            if (out_free) state_in = (t_ff == 2'd3) ? ST_LEVEL : ST_TRI;
         end
         ST_FLUSH:  if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // --------------------------------------------------------------- datapath
   always_comb begin
      lo_a = (req_height_sw < req_height_se) ? req_height_sw : req_height_se;
      lo_b = (req_height_ne < req_height_nw) ? req_height_ne : req_height_nw;
      hi_a = (req_height_sw > req_height_se) ? req_height_sw : req_height_se;
      hi_b = (req_height_ne > req_height_nw) ? req_height_ne : req_height_nw;
      lo_in = (lo_a < lo_b) ? lo_a : lo_b;
      hi_in = (hi_a > hi_b) ? hi_a : hi_b;
      kcount_in = (32'(lcount_ff) > MAX_LEVELS) ? KW'(MAX_LEVELS) : KW'(lcount_ff);

      xmid = {(17'(xl_ff) + 17'(xr_ff)), 3'b000};
      ymid = {(17'(yl_ff) + 17'(yr_ff)), 3'b000};
      vux  = vcoord(vu, 1'b0, xmid, ymid, xl_ff, xr_ff, yl_ff, yr_ff);
      vuy  = vcoord(vu, 1'b1, xmid, ymid, xl_ff, xr_ff, yl_ff, yr_ff);
      vvx  = vcoord(vv, 1'b0, xmid, ymid, xl_ff, xr_ff, yl_ff, yr_ff);
      vvy  = vcoord(vv, 1'b1, xmid, ymid, xl_ff, xr_ff, yl_ff, yr_ff);

      for (int i = 0; i < 4; i++) begin
         dlev[i] = LEV_W'(cor_ff[i]) - lev_ff;
      end
      hsum = H_W'(h_ff[1] >>> 2) + H_W'(h_ff[2] >>> 2) + H_W'(h_ff[3] >>> 2)
           + H_W'(h_ff[4] >>> 2);

      // One multiplier serves both products of a crossing.
      if (state_ff == ST_MULA) begin
         mul_h = magv_ff;
         mul_p = axis_ff ? puy_ff : pux_ff;
      end else begin
         mul_h = magu_ff;
         mul_p = axis_ff ? pvy_ff : pvx_ff;
      end
      mul_out = PROD_W'(mul_h) * PROD_W'(mul_p);
      num     = NUM_W'(prod_ff) + NUM_W'(prod2_ff);

      dtry = {rem_ff, sh_ff[P_W-1]};
      dge  = (dtry >= {1'b0, den_ff});
      dsub = dge ? (dtry - {1'b0, den_ff}) : dtry;
      quot = {sh_ff[P_W-2:0], dge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         base_ff       <= '0;
         step_ff       <= COORD_W'(1);
         lcount_ff     <= CNT_W'(1);
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_LEVEL_BASE:  base_ff   <= csr_wdata;
               CSR_LEVEL_STEP:  step_ff   <= csr_wdata;
               CSR_LEVEL_COUNT: lcount_ff <= csr_wdata[CNT_W-1:0];
               default: ;
            endcase
         end

         if (out_load) out_valid_ff <= 1'b1;
         else if (!rsp_stall) out_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  cor_ff[0] <= req_height_sw;
                  cor_ff[1] <= req_height_se;
                  cor_ff[2] <= req_height_ne;
                  cor_ff[3] <= req_height_nw;
                  lo_ff     <= lo_in;
                  hi_ff     <= hi_in;
                  xl_ff     <= req_x_lo;
                  xr_ff     <= req_x_hi;
                  yl_ff     <= req_y_lo;
                  yr_ff     <= req_y_hi;
                  lev_ff    <= LEV_W'(base_ff);
                  k_ff      <= '0;
                  kcount_ff <= kcount_in;
               end
            end
            ST_LEVEL: begin
               if (k_ff != kcount_ff) begin
                  if (lev_out) begin
                     k_ff   <= k_ff + KW'(1);
                     lev_ff <= lev_ff + LEV_W'(step_ff);
                  end else begin
                     for (int i = 0; i < 4; i++) begin
                        h_ff[i+1] <= {dlev[i][H_W-3:0], 2'b00};
                     end
                  end
               end
            end
            ST_CENTER: begin
               h_ff[0] <= hsum;
               t_ff    <= 2'd0;
            end
            ST_TRI: begin
               cv_ff <= cv_in;
               e_ff  <= 1'b0;
               if (tri_empty) begin
                  if (t_ff == 2'd3) begin
                     k_ff   <= k_ff + KW'(1);
                     lev_ff <= lev_ff + LEV_W'(step_ff);
                  end else begin
                     t_ff <= t_ff + 2'd1;
                  end
               end
            end
            ST_ENDP: begin
               magu_ff <= mag_of(h_ff[vu]);
               magv_ff <= mag_of(h_ff[vv]);
               pux_ff  <= vux;
               puy_ff  <= vuy;
               pvx_ff  <= vvx;
               pvy_ff  <= vvy;
               axis_ff <= 1'b0;
               if (!ep.is_x) begin
                  if (e_ff) begin
                     ex_ff <= vux;
                     ey_ff <= vuy;
                  end else begin
                     sx_ff <= vux;
                     sy_ff <= vuy;
                     e_ff  <= 1'b1;
                  end
               end
            end
            ST_MULA:  prod_ff  <= mul_out;
            ST_MULB:  prod2_ff <= mul_out;
            ST_DIVLD: begin
               // The quotient is a weighted mean of two coordinates, so it
               // fits in P_W bits and the high part is already below den.
               rem_ff  <= num[NUM_W-1:P_W];
               sh_ff   <= num[P_W-1:0];
               den_ff  <= DEN_W'(magu_ff) + DEN_W'(magv_ff);
               dcnt_ff <= '0;
            end
            ST_DIV: begin
               rem_ff  <= dsub[DEN_W-1:0];
               sh_ff   <= quot;
               dcnt_ff <= dcnt_ff + DCNT_W'(1);
               if (div_last) begin
                  unique case ({e_ff, axis_ff})
                     2'b00: sx_ff <= quot;
                     2'b01: sy_ff <= quot;
                     2'b10: ex_ff <= quot;
                     default: ey_ff <= quot;
                  endcase
                  axis_ff <= !axis_ff;
                  if (axis_ff && !e_ff) e_ff <= 1'b1;
               end
            end
            ST_PUSH: begin
               if (out_free) begin
                  if (pend_valid_ff) begin
                     out_last_ff  <= 1'b0;
                     out_lidx_ff  <= pend_lidx_ff;
                     out_sx_ff    <= pend_sx_ff;
                     out_sy_ff    <= pend_sy_ff;
                     out_ex_ff    <= pend_ex_ff;
                     out_ey_ff    <= pend_ey_ff;
                  end
                  pend_valid_ff <= 1'b1;
                  pend_lidx_ff  <= LIDX_W'(k_ff);
                  pend_sx_ff    <= sx_ff;
                  pend_sy_ff    <= sy_ff;
                  pend_ex_ff    <= ex_ff;
                  pend_ey_ff    <= ey_ff;
                  if (t_ff == 2'd3) begin
                     k_ff   <= k_ff + KW'(1);
                     lev_ff <= lev_ff + LEV_W'(step_ff);
                  end else begin
                     t_ff <= t_ff + 2'd1;
                  end
               end
            end
            ST_FLUSH: begin
               if (out_free && pend_valid_ff) begin
                  out_last_ff   <= 1'b1;
                  out_lidx_ff   <= pend_lidx_ff;
                  out_sx_ff     <= pend_sx_ff;
                  out_sy_ff     <= pend_sy_ff;
                  out_ex_ff     <= pend_ex_ff;
                  out_ey_ff     <= pend_ey_ff;
                  pend_valid_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_level_index = out_lidx_ff;
   assign rsp_start_x     = out_sx_ff;
   assign rsp_start_y     = out_sy_ff;
   assign rsp_end_x       = out_ex_ff;
   assign rsp_end_y       = out_ey_ff;
   assign rsp_last        = out_last_ff;

   // ------------------------------------------------------------- assertions
   `CCS_ASSERT_NOW(a_div_nonzero, clock, reset, state_ff == ST_DIV, den_ff != '0, "divider saw a zero divisor")
   `CCS_ASSERT_NOW(a_div_rem, clock, reset, state_ff == ST_DIV, rem_ff < den_ff, "divider remainder not below divisor")
   `CCS_ASSERT_NOW(a_idle_drained, clock, reset, state_ff == ST_IDLE, !pend_valid_ff, "segment left pending after a cell")
   `CCS_ASSERT_NEXT(a_accept_start, clock, reset, req_valid && !req_stall, state_ff == ST_LEVEL && k_ff == '0, "cell not started at level zero")

endmodule

FILE: bench/contour_segment_checker.sv
// ----------------------------------------------------------------------------
// Contour segment checker
// Watches the cell, segment and register channels of the contour core,
// predicts the segments of every accepted cell and compares them in order.
// ----------------------------------------------------------------------------
module contour_segment_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic signed [ccs_pkg::COORD_W-1:0] req_height_sw,
   input  logic signed [ccs_pkg::COORD_W-1:0] req_height_se,
   input  logic signed [ccs_pkg::COORD_W-1:0] req_height_ne,
   input  logic signed [ccs_pkg::COORD_W-1:0] req_height_nw,
   input  logic [ccs_pkg::COORD_W-1:0]        req_x_lo,
   input  logic [ccs_pkg::COORD_W-1:0]        req_x_hi,
   input  logic [ccs_pkg::COORD_W-1:0]        req_y_lo,
   input  logic [ccs_pkg::COORD_W-1:0]        req_y_hi,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [ccs_pkg::LIDX_W-1:0]         rsp_level_index,
   input  logic [ccs_pkg::P_W-1:0]            rsp_start_x,
   input  logic [ccs_pkg::P_W-1:0]            rsp_start_y,
   input  logic [ccs_pkg::P_W-1:0]            rsp_end_x,
   input  logic [ccs_pkg::P_W-1:0]            rsp_end_y,
   input  logic                               rsp_last,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [ccs_pkg::CIDX_W-1:0]         csr_index,
   input  logic [ccs_pkg::COORD_W-1:0]        csr_wdata,
   output int                                 mismatches,
   output int                                 pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import ccs_pkg::*;

   localparam int LEVELS_MAX = 16;

   typedef enum int {
      NO_SEG, SIDE_AC, SIDE_CB, SIDE_BA, A_TO_CB, C_TO_BA, B_TO_AC,
      AC_TO_CB, CB_TO_BA, BA_TO_AC
   } tri_kind_type;

   // Indexed by the signs of corner a, centre and corner b, each as below/on/above.
   localparam tri_kind_type TRI_KIND [27] = '{
      NO_SEG,   NO_SEG,   CB_TO_BA, NO_SEG,  SIDE_CB, C_TO_BA, AC_TO_CB, B_TO_AC, BA_TO_AC,
      NO_SEG,   SIDE_BA,  A_TO_CB,  SIDE_AC, SIDE_BA, SIDE_AC, A_TO_CB,  SIDE_BA, NO_SEG,
      BA_TO_AC, B_TO_AC,  AC_TO_CB, C_TO_BA, SIDE_CB, NO_SEG,  CB_TO_BA, NO_SEG,  NO_SEG
   };

   typedef struct {
      logic [LIDX_W-1:0] level;
      logic [P_W-1:0]    sx;
      logic [P_W-1:0]    sy;
      logic [P_W-1:0]    ex;
      logic [P_W-1:0]    ey;
      logic              last;
   } segment_type;

   segment_type        segments_due[$];
   logic signed [15:0] cfg_base;
   logic [15:0]        cfg_step;
   logic [CNT_W-1:0]   cfg_count;

   function automatic longint cross_point(longint ha, longint hb, longint pa, longint pb);
      longint ma, mb;
      ma = ha < 0 ? -ha : ha;
      mb = hb < 0 ? -hb : hb;
      if (ma + mb == 0) return pa;
      return (mb * pa + ma * pb) / (ma + mb);
   endfunction

   function automatic int sign3(longint v);
      return v > 0 ? 2 : (v < 0 ? 0 : 1);
   endfunction

   function automatic void predict_segments(longint hc[4], longint xl, longint xr,
                                            longint yl, longint yr);
      longint px[5], py[5], h[5];
      longint lo, hi, lev, x1, y1, x2, y2;
      int count, a, b, seg_n;
      tri_kind_type kind;
      segment_type s;
      seg_n = 0;
      px[1] = xl; py[1] = yl; px[2] = xr; py[2] = yl;
      px[3] = xr; py[3] = yr; px[4] = xl; py[4] = yr;
      px[0] = (xl + xr) / 2;
      py[0] = (yl + yr) / 2;
      lo = hc[0]; hi = hc[0];
      for (int i = 1; i < 4; i++) begin
         if (hc[i] < lo) lo = hc[i];
         if (hc[i] > hi) hi = hc[i];
      end
      count = cfg_count > LEVELS_MAX ? LEVELS_MAX : cfg_count;
      for (int k = 0; k < count; k++) begin
         lev = longint'(cfg_base) + longint'(cfg_step) * k;
         if (lev < lo || lev > hi) continue;
         h[0] = 0;
         for (int i = 1; i <= 4; i++) begin
            h[i] = 4 * (hc[i-1] - lev);
            h[0] += hc[i-1] - lev;
         end
         for (int t = 1; t <= 4; t++) begin
            a = t;
            b = (t == 4) ? 1 : t + 1;
            kind = TRI_KIND[sign3(h[a]) * 9 + sign3(h[0]) * 3 + sign3(h[b])];
            case (kind)
               SIDE_AC: begin
                  x1 = px[a]; y1 = py[a]; x2 = px[0]; y2 = py[0];
               end
               SIDE_CB: begin
                  x1 = px[0]; y1 = py[0]; x2 = px[b]; y2 = py[b];
               end
               SIDE_BA: begin
                  x1 = px[b]; y1 = py[b]; x2 = px[a]; y2 = py[a];
               end
               A_TO_CB: begin
                  x1 = px[a]; y1 = py[a];
                  x2 = cross_point(h[0], h[b], px[0], px[b]);
                  y2 = cross_point(h[0], h[b], py[0], py[b]);
               end
               C_TO_BA: begin
                  x1 = px[0]; y1 = py[0];
                  x2 = cross_point(h[b], h[a], px[b], px[a]);
                  y2 = cross_point(h[b], h[a], py[b], py[a]);
               end
               B_TO_AC: begin
                  x1 = px[b]; y1 = py[b];
                  x2 = cross_point(h[a], h[0], px[a], px[0]);
                  y2 = cross_point(h[a], h[0], py[a], py[0]);
               end
               AC_TO_CB: begin
                  x1 = cross_point(h[a], h[0], px[a], px[0]);
                  y1 = cross_point(h[a], h[0], py[a], py[0]);
                  x2 = cross_point(h[0], h[b], px[0], px[b]);
                  y2 = cross_point(h[0], h[b], py[0], py[b]);
               end
               CB_TO_BA: begin
                  x1 = cross_point(h[0], h[b], px[0], px[b]);
                  y1 = cross_point(h[0], h[b], py[0], py[b]);
                  x2 = cross_point(h[b], h[a], px[b], px[a]);
                  y2 = cross_point(h[b], h[a], py[b], py[a]);
               end
               BA_TO_AC: begin
                  x1 = cross_point(h[b], h[a], px[b], px[a]);
                  y1 = cross_point(h[b], h[a], py[b], py[a]);
                  x2 = cross_point(h[a], h[0], px[a], px[0]);
                  y2 = cross_point(h[a], h[0], py[a], py[0]);
               end
               default: continue;
            endcase
            s.level = k[LIDX_W-1:0];
            s.sx = x1[P_W-1:0];
            s.sy = y1[P_W-1:0];
            s.ex = x2[P_W-1:0];
            s.ey = y2[P_W-1:0];
            s.last = 1'b0;
            segments_due = {segments_due, s};
            seg_n++;
         end
      end
      if (seg_n > 0) segments_due[segments_due.size()-1].last = 1'b1;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("%0t: segment %s is %0d, predicted %0d", $realtime, field, got, want);
      mismatches++;
   endtask

   initial begin
      mismatches = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      segment_type s;
      longint hc[4];
      if (reset) begin
         cfg_base = 16'sd0;
         cfg_step = 16'd1;
         cfg_count = 5'd1;
         segments_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (segments_due.size() == 0) begin
               report_mismatch("with nothing predicted, start_x", rsp_start_x, -1);
            end else begin
               s = segments_due.pop_front();
               if (rsp_level_index != s.level)
                  report_mismatch("level_index", rsp_level_index, s.level);
               if (rsp_start_x != s.sx) report_mismatch("start_x", rsp_start_x, s.sx);
               if (rsp_start_y != s.sy) report_mismatch("start_y", rsp_start_y, s.sy);
               if (rsp_end_x != s.ex) report_mismatch("end_x", rsp_end_x, s.ex);
               if (rsp_end_y != s.ey) report_mismatch("end_y", rsp_end_y, s.ey);
               if (rsp_last != s.last) report_mismatch("last", rsp_last, s.last);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LEVEL_BASE:  cfg_base = csr_wdata;
               CSR_LEVEL_STEP:  cfg_step = csr_wdata;
               CSR_LEVEL_COUNT: cfg_count = csr_wdata[CNT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            hc[0] = longint'(req_height_sw);
            hc[1] = longint'(req_height_se);
            hc[2] = longint'(req_height_ne);
            hc[3] = longint'(req_height_nw);
            predict_segments(hc, longint'(req_x_lo) * 16, longint'(req_x_hi) * 16,
                             longint'(req_y_lo) * 16, longint'(req_y_hi) * 16);
         end
      end
      pending = segments_due.size();
   end

endmodule

FILE: bench/contour_cell_segments_core_test.sv
// ----------------------------------------------------------------------------
// Contour cell segments core testbench
// Directed and random grid cells over several level settings, with random
// idling on both channels and two long output hold-offs; a checker predicts
// and compares every segment.
// ----------------------------------------------------------------------------
module contour_cell_segments_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ccs_pkg::*;

   localparam int DRAIN_CYCLES = 8;
   localparam int STUCK_LIMIT  = 40000;
   localparam int HOLD_CYCLES  = 3000;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic signed [COORD_W-1:0]   req_height_sw, req_height_se, req_height_ne, req_height_nw;
   logic [COORD_W-1:0]          req_x_lo, req_x_hi, req_y_lo, req_y_hi;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [LIDX_W-1:0]           rsp_level_index;
   logic [P_W-1:0]              rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y;
   logic                        rsp_last;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CIDX_W-1:0]           csr_index;
   logic [COORD_W-1:0]          csr_wdata;
   int                          mismatches;
   int                          pending;

   int                          send_idle_pct, recv_idle_pct;
   int                          hold_asked, hold_seen, hold_left;
   int                          stuck_cycles;
   int                          lvl_base, lvl_step, lvl_count;

   contour_cell_segments_core dut (.*);

   contour_segment_checker checker_i (.*);

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Output side: random stalls, plus a long hold-off whenever one is asked for.
   always @(posedge clock) begin
      if (hold_asked != hold_seen) begin
         hold_seen = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_cell(int sw, int se, int ne, int nw, int xl, int xh, int yl, int yh);
      req_valid     <= 1'b1;
      req_height_sw <= sw[15:0];
      req_height_se <= se[15:0];
      req_height_ne <= ne[15:0];
      req_height_nw <= nw[15:0];
      req_x_lo      <= xl[15:0];
      req_x_hi      <= xh[15:0];
      req_y_lo      <= yl[15:0];
      req_y_hi      <= yh[15:0];
      do @(posedge clock); while (req_stall);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic write_reg(logic [CIDX_W-1:0] idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[15:0];
      do @(posedge clock); while (!csr_ready);
   endtask

   // The block is back in its idle state and every predicted segment is out.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0 || req_stall) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_levels(int base, int step, int count);
      lvl_base = base;
      lvl_step = step;
      lvl_count = count;
      write_reg(CSR_LEVEL_BASE, base);
      write_reg(CSR_LEVEL_STEP, step);
      write_reg(CSR_LEVEL_COUNT, count);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int clamp16(int v);
      return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
   endfunction

   // Mostly corners clustered around a random height so that levels cut the
   // cell; some fully random cells and some corners placed exactly on a level.
   task automatic send_random_cell();
      int hv[4];
      int centre, spread, mode, k, n;
      mode = $urandom_range(99);
      centre = int'($urandom_range(65535)) - 32768;
      spread = $urandom_range(1, 3) == 1 ? 40000 : $urandom_range(1, 9000);
      n = lvl_count > 16 ? 16 : lvl_count;
      for (int i = 0; i < 4; i++) begin
         if (mode < 20)
            hv[i] = int'($urandom_range(65535)) - 32768;
         else
            hv[i] = clamp16(centre + int'($urandom_range(2 * spread)) - spread);
         if (mode >= 70 && n > 0 && $urandom_range(2) == 0) begin
            k = $urandom_range(n - 1);
            hv[i] = clamp16(lvl_base + lvl_step * k);
         end
      end
      send_cell(hv[0], hv[1], hv[2], hv[3], $urandom_range(65535), $urandom_range(65535),
                $urandom_range(65535), $urandom_range(65535));
   endtask

   task automatic random_phase(int items);
      repeat (items) send_random_cell();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      {req_height_sw, req_height_se, req_height_ne, req_height_nw} = '0;
      {req_x_lo, req_x_hi, req_y_lo, req_y_hi} = '0;
      csr_valid = 1'b0;
      csr_index = CSR_LEVEL_BASE;
      csr_wdata = '0;
      rsp_stall = 1'b0;
      send_idle_pct = 37;
      recv_idle_pct = 86;
      hold_asked = 0;
      hold_seen = 0;
      hold_left = 0;
      stuck_cycles = 0;
      lvl_base = 0;
      lvl_step = 1;
      lvl_count = 1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default setting: a single level at height zero.
      send_cell(0, 0, 0, 0, 0, 65535, 0, 65535);
      send_cell(0, 0, 0, 0, 65535, 0, 65535, 0);
      send_cell(-32768, 32767, 32767, 32767, 0, 65535, 0, 65535);
      send_cell(32767, -32768, -32768, -32768, 65535, 65535, 0, 0);
      send_cell(0, 1, 0, -1, 10, 20, 30, 40);
      send_cell(5, 5, 5, 5, 1, 2, 3, 4);
      send_cell(-5, -5, -5, -5, 1, 2, 3, 4);
      send_cell(100, -100, 100, -100, 100, 200, 300, 400);
      send_cell(0, 0, 10, 10, 7, 9, 11, 13);
      send_cell(-1, 1, 1, -1, 3, 4, 7, 8);
      send_cell(0, 0, 0, -7, 1000, 2000, 1000, 2000);
      send_cell(3, -3, -3, 3, 65535, 65534, 0, 1);
      send_cell(-32768, -32768, 32767, 32767, 43690, 21845, 21845, 43690);
      send_cell(32767, 0, -32768, 0, 0, 65535, 65535, 0);
      wait_drained();

      set_levels(-32768, 4096, 16);
      random_phase(154);
      wait_drained();

      send_idle_pct = 86;
      recv_idle_pct = 37;
      set_levels(-1000, 700, 3);
      random_phase(120);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_levels(32767, 65535, 31);
      hold_asked++;
      random_phase(60);
      wait_drained();

      set_levels(0, 0, 0);
      random_phase(12);
      wait_drained();

      set_levels(5, 0, 2);
      hold_asked++;
      random_phase(20);
      wait_drained();

      if (mismatches == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/ccs_pkg.sv
rtl/core/contour_cell_segments_core.sv
bench/contour_segment_checker.sv
bench/contour_cell_segments_core_test.sv
